@@ hdl/greedy_task_to_robot_assigner_unit_defines.svh @@
// Assertion macros for the greedy task assigner checker.
// Expects clk and rst_n in the scope that uses them; no other dependencies.
`ifndef GREEDY_TASK_TO_ROBOT_ASSIGNER_UNIT_DEFINES_SVH
`define GREEDY_TASK_TO_ROBOT_ASSIGNER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GTRA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtra: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define GTRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtra: next-cycle check failed");

`endif

@@ hdl/gtra_pkg.sv @@
// Shared constants and types for the greedy task assigner.
// No dependencies; imported by gtra_cmp, the top level and the checker.
package gtra_pkg;

  localparam int COST_W   = 16;          // Q12.4 travel cost
  localparam int TIME_W   = 32;          // Q28.4 busy time
  localparam int SUM_W    = TIME_W + 2;  // busy + two costs, full precision
  localparam int NODE_PW  = 6;           // node field width on the ports
  localparam int ROBOT_PW = 4;           // robot field width on the ports
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 5;
  localparam int ROB_WORD_W = NODE_PW + TIME_W;  // {end node, busy time}

  localparam logic [CFG_W-1:0] ROBOT_COUNT_RST = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_COST  = 2'd0,
    MODE_START = 2'd1,
    MODE_TASK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Controls the compare stage.
  typedef struct packed {
    logic vld;    // a candidate arrives this cycle
    logic first;  // candidate is robot 0: load unconditionally
  } cmp_ctrl_t;

endpackage

@@ hdl/gtra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/gtra_cmp.sv @@
// Final adder and running-minimum register of the robot scan.
// Depends on gtra_pkg.
module gtra_cmp #(
  parameter int ROB_W = 4
) (
  input  logic                          clk,
  input  gtra_pkg::cmp_ctrl_t           ctrl,
  input  logic [ROB_W-1:0]              idx,
  input  logic [gtra_pkg::TIME_W:0]     part_sum,
  input  logic [gtra_pkg::COST_W-1:0]   cost,
  output logic [gtra_pkg::SUM_W-1:0]    best_total,
  output logic [ROB_W-1:0]              best_idx
);

  import gtra_pkg::*;

  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] best_total_r;
  logic [ROB_W-1:0] best_idx_r;

  assign total = SUM_W'(part_sum) + SUM_W'(cost);

  // strict less-than keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (ctrl.vld && (ctrl.first || (total < best_total_r))) begin
      best_total_r <= total;
      best_idx_r   <= idx;
    end
  end

  assign best_total = best_total_r;
  assign best_idx   = best_idx_r;

endmodule

@@ hdl/greedy_task_to_robot_assigner_unit.sv @@
// Top level of the greedy task assigner: sequencer, robot scan and memories.
// Depends on gtra_pkg, gtra_ram and gtra_cmp.
//
// Greedy task-to-robot assigner. A cost-write transfer (mode 0) stores one
// Q12.4 travel cost in the node-to-node cost memory; a start transfer (mode 1)
// places a robot on a node with zero busy time; a task transfer (mode 2)
// scans the active robots (robot_count, clamped to 1..MAX_ROBOTS) and picks
// the one with the least busy time + cost(end node, source) +
// cost(source, destination), ties to the lowest index. That robot takes the
// saturated total as its busy time and the destination as its end node, and
// one result transfer reports it. Cost and start transfers give no result;
// so do unused mode 3 and tasks with a node beyond the table. A task
// occupies the block for delivery-cost fetch, a scan that issues one
// robot-memory read per cycle, each feeding one read on the cost memory's
// single read port, three stages deep, and write-back. A finished result
// sits in the output register while the next item is taken. Cost entries
// must be written before they are read; robot state resets to zero through
// per-robot valid bits, so no clearing pass is needed. The user must write
// configuration only while idle; the block itself does not enforce it.
module greedy_task_to_robot_assigner_unit #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_ROBOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [gtra_pkg::CFG_W-1:0]        cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gtra_pkg::MODE_W-1:0]       in_mode,
  input  logic [gtra_pkg::ROBOT_PW-1:0]     in_robot_index,
  input  logic [gtra_pkg::NODE_PW-1:0]      in_from_node,
  input  logic [gtra_pkg::NODE_PW-1:0]      in_to_node,
  input  logic [gtra_pkg::COST_W-1:0]       in_cost_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gtra_pkg::ROBOT_PW-1:0]     out_chosen_robot,
  output logic [gtra_pkg::TIME_W-1:0]       out_finish_time,
  output logic                              out_time_saturated
);

  import gtra_pkg::*;

  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int COST_DEPTH = 1 << (2 * NODE_W);
  localparam int ROB_W      = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_ROBOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB
  } state_t;

  state_t state_r, state_nxt;

  // control
  logic [CFG_W-1:0]      robot_count_r;
  logic [CNT_W-1:0]      n_active;
  logic [CNT_W-1:0]      cnt_r;
  logic [MAX_ROBOTS-1:0] vld_r;
  logic                  a_v_r, b_v_r;
  logic                  out_valid_r;

  // payload
  logic [NODE_PW-1:0]    from_r, to_r;
  logic [COST_W-1:0]     delivery_r;
  logic [ROB_W-1:0]      a_idx_r, b_idx_r;
  logic                  a_ok_r;
  logic [TIME_W:0]       b_bd_r;
  logic [ROBOT_PW-1:0]   out_chosen_r;
  logic [TIME_W-1:0]     out_finish_r;
  logic                  out_sat_r;

  logic in_acc, from_ok, to_ok, task_acc, cost_acc, start_acc;
  logic issuing, scan_done, wb_go;

  // memory ports
  logic [2*NODE_W-1:0]   cost_waddr, cost_raddr;
  logic [COST_W-1:0]     cost_rdata;
  logic                  cost_we;
  logic                  rob_we;
  logic [ROB_W-1:0]      rob_waddr;
  logic [ROB_WORD_W-1:0] rob_wdata, rob_rdata, rob_word;

  logic [NODE_PW-1:0]    b_end;
  logic [TIME_W-1:0]     b_busy;
  logic [SUM_W-1:0]      best_total;
  logic [ROB_W-1:0]      best_idx;
  logic                  sat;
  logic [TIME_W-1:0]     fin;
  cmp_ctrl_t             cmp_ctrl;

  // ---------------------------------------------------------------- decode
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign from_ok   = (32'(in_from_node) < MAX_NODES);
  assign to_ok     = (32'(in_to_node) < MAX_NODES);
  assign cost_acc  = in_acc && (in_mode == MODE_COST) && from_ok && to_ok;
  assign start_acc = in_acc && (in_mode == MODE_START) && from_ok &&
                     (32'(in_robot_index) < MAX_ROBOTS);
  // out-of-range task is dropped: no result, no state change
  assign task_acc  = in_acc && (in_mode == MODE_TASK) && from_ok && to_ok;

  // robot_count clamp: 0 acts as 1, above MAX_ROBOTS acts as MAX_ROBOTS
  always_comb begin
    if (robot_count_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(robot_count_r) > MAX_ROBOTS) begin
      n_active = CNT_W'(MAX_ROBOTS);
    end else begin
      n_active = CNT_W'(robot_count_r);
    end
  end

  assign issuing   = (state_r == S_SCAN) && (cnt_r < n_active);
  assign scan_done = (state_r == S_SCAN) && !issuing && !a_v_r && !b_v_r;
  assign wb_go     = (state_r == S_WB) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------- cost memory
  // Idle: delivery cost read straight from the ports so it lands on the
  // first scan cycle. Scan: stage B reads cost(end node, source).
  assign cost_we    = cost_acc;
  assign cost_waddr = {NODE_W'(in_from_node), NODE_W'(in_to_node)};
  assign cost_raddr = (state_r == S_IDLE) ?
                      {NODE_W'(in_from_node), NODE_W'(in_to_node)} :
                      {NODE_W'(b_end), NODE_W'(from_r)};

  gtra_ram #(
    .WIDTH (COST_W),
    .DEPTH (COST_DEPTH)
  ) u_cost_ram (
    .clk     (clk),
    .we      (cost_we),
    .waddr   (cost_waddr),
    .wdata   (in_cost_value),
    .raddr   (cost_raddr),
    .rd_data (cost_rdata)
  );

  // --------------------------------------------------------- robot memory
  // Start transfer and write-back never coincide (different states), so
  // the write port is a plain mux. Write-back lands before the next item
  // is taken, so the scan never overlaps a pending write.
  assign sat = |best_total[SUM_W-1:TIME_W];
  assign fin = sat ? '1 : best_total[TIME_W-1:0];

  assign rob_we    = start_acc || wb_go;
  assign rob_waddr = wb_go ? best_idx : ROB_W'(in_robot_index);
  assign rob_wdata = wb_go ? {to_r, fin} : {in_from_node, TIME_W'(0)};

  gtra_ram #(
    .WIDTH (ROB_WORD_W),
    .DEPTH (MAX_ROBOTS)
  ) u_rob_ram (
    .clk     (clk),
    .we      (rob_we),
    .waddr   (rob_waddr),
    .wdata   (rob_wdata),
    .raddr   (cnt_r[ROB_W-1:0]),
    .rd_data (rob_rdata)
  );

  // never-written robot reads as node 0, time 0
  assign rob_word = a_ok_r ? rob_rdata : '0;
  assign b_end    = rob_word[ROB_WORD_W-1:TIME_W];
  assign b_busy   = rob_word[TIME_W-1:0];

  // ---------------------------------------------------------- compare stage
  assign cmp_ctrl.vld   = b_v_r;
  assign cmp_ctrl.first = (b_idx_r == '0);

  gtra_cmp #(
    .ROB_W (ROB_W)
  ) u_cmp (
    .clk        (clk),
    .ctrl       (cmp_ctrl),
    .idx        (b_idx_r),
    .part_sum   (b_bd_r),
    .cost       (cost_rdata),
    .best_total (best_total),
    .best_idx   (best_idx)
  );

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (task_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_WB;
      end
      S_WB: begin
        if (wb_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      robot_count_r <= ROBOT_COUNT_RST;
      cnt_r         <= '0;
      vld_r         <= '0;
      a_v_r         <= 1'b0;
      b_v_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) robot_count_r <= cfg_wr_data;
      if (rob_we) vld_r[rob_waddr] <= 1'b1;
      if (task_acc) begin
        cnt_r <= '0;
      end else if (issuing) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      a_v_r <= issuing;
      b_v_r <= a_v_r;
      if (wb_go) begin
        out_valid_r  <= 1'b1;
        out_chosen_r <= ROBOT_PW'(best_idx);
        out_finish_r <= fin;
        out_sat_r    <= sat;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // scan pipeline payload: A = robot read, B = cost read, C = compare
  always_ff @(posedge clk) begin
    if (task_acc) begin
      from_r <= in_from_node;
      to_r   <= in_to_node;
    end
    if ((state_r == S_SCAN) && (cnt_r == '0)) begin
      delivery_r <= cost_rdata;
    end
    a_idx_r <= cnt_r[ROB_W-1:0];
    a_ok_r  <= issuing && vld_r[cnt_r[ROB_W-1:0]];
    b_idx_r <= a_idx_r;
    b_bd_r  <= (TIME_W + 1)'(b_busy) + (TIME_W + 1)'(delivery_r);
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_robot   = out_chosen_r;
  assign out_finish_time    = out_finish_r;
  assign out_time_saturated = out_sat_r;

endmodule

@@ hdl/gtra_chk.sv @@
// Port-level checker for the greedy task assigner, bound to the top level.
// Depends on gtra_pkg and greedy_task_to_robot_assigner_unit_defines.svh.
`include "greedy_task_to_robot_assigner_unit_defines.svh"

module gtra_chk #(
  parameter int MAX_NODES = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [gtra_pkg::MODE_W-1:0]       in_mode,
  input logic [gtra_pkg::NODE_PW-1:0]      in_from_node,
  input logic [gtra_pkg::NODE_PW-1:0]      in_to_node,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gtra_pkg::ROBOT_PW-1:0]     out_chosen_robot,
  input logic [gtra_pkg::TIME_W-1:0]       out_finish_time,
  input logic                              out_time_saturated
);

  import gtra_pkg::*;

  logic task_in, write_in;
  logic [ROBOT_PW+TIME_W:0] out_word;

  assign task_in  = in_valid && in_ready && (in_mode == MODE_TASK) &&
                    (32'(in_from_node) < MAX_NODES) && (32'(in_to_node) < MAX_NODES);
  assign write_in = in_valid && in_ready &&
                    ((in_mode == MODE_COST) || (in_mode == MODE_START));
  assign out_word = {out_chosen_robot, out_finish_time, out_time_saturated};

  // stalled result holds
  `GTRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // saturation flag only with the clipped maximum
  `GTRA_ASSERT_SAME(a_sat_max, out_valid && out_time_saturated, out_finish_time == '1)
  // a valid task occupies the block
  `GTRA_ASSERT_NEXT(a_task_busy, task_in, !in_ready)
  // cost and start transfers leave the block ready again in the next cycle
  `GTRA_ASSERT_NEXT(a_write_quick, write_in, in_ready)

endmodule

bind greedy_task_to_robot_assigner_unit gtra_chk #(.MAX_NODES(MAX_NODES)) u_gtra_chk (.*);
